@@ design/caf_pkg.sv @@
// Shared types and constants for the cubic anisotropy field pipeline.
`default_nettype none

package caf_pkg;

   localparam int VEC_W   = 16;  // Q1.15 vector components
   localparam int CSR_W   = 32;  // register and bus data width
   localparam int FIELD_W = 48;  // saturated output field width

   localparam logic signed [FIELD_W-1:0] FIELD_MAX = {1'b0, {(FIELD_W-1){1'b1}}};
   localparam logic signed [FIELD_W-1:0] FIELD_MIN = {1'b1, {(FIELD_W-1){1'b0}}};

   // Register index, taken from the word address.
   typedef enum logic {
      CSR_K_FIRST  = 1'b0,
      CSR_K_SECOND = 1'b1
   } csr_index_type;

   // Nine easy-axis components, element j*3+c holds component c of axis j.
   typedef logic [8:0][VEC_W-1:0] axes_type;

endpackage

`default_nettype wire

@@ design/cubic_anisotropy_field.sv @@
// Cubic magnetocrystalline anisotropy field, thirteen-stage pipeline.
//
// One mesh node is taken per clock: start is accepted in every cycle and busy
// stays low. Each item's field appears on the rsp_ ports, marked by rsp_valid,
// once the item has passed all thirteen pipeline registers. The stage count is
// set by the chain of dependent multiplications (projection, square, pairwise
// product, constant scaling, derivative, rotation back), each followed by a
// register, with the wide 74-bit and 66-bit rounding steps on stages of their
// own. The receiver cannot stall the pipeline, so nothing waits inside it.
// K1 and K2 are read in the middle of the pipeline; write them only when no
// item is in flight.
`default_nettype none

module cubic_anisotropy_field (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // Command channel
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic signed [caf_pkg::VEC_W-1:0]   req_mag_x,
   input  wire logic signed [caf_pkg::VEC_W-1:0]   req_mag_y,
   input  wire logic signed [caf_pkg::VEC_W-1:0]   req_mag_z,
   input  wire logic signed [caf_pkg::VEC_W-1:0]   req_axis1_x,
   input  wire logic signed [caf_pkg::VEC_W-1:0]   req_axis1_y,
   input  wire logic signed [caf_pkg::VEC_W-1:0]   req_axis1_z,
   input  wire logic signed [caf_pkg::VEC_W-1:0]   req_axis2_x,
   input  wire logic signed [caf_pkg::VEC_W-1:0]   req_axis2_y,
   input  wire logic signed [caf_pkg::VEC_W-1:0]   req_axis2_z,
   input  wire logic signed [caf_pkg::VEC_W-1:0]   req_axis3_x,
   input  wire logic signed [caf_pkg::VEC_W-1:0]   req_axis3_y,
   input  wire logic signed [caf_pkg::VEC_W-1:0]   req_axis3_z,
   // Result channel
   output logic                                    rsp_valid,
   output logic signed [caf_pkg::FIELD_W-1:0]      rsp_field_x,
   output logic signed [caf_pkg::FIELD_W-1:0]      rsp_field_y,
   output logic signed [caf_pkg::FIELD_W-1:0]      rsp_field_z,
   // Configuration port
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [2:0]                         paddr,
   input  wire logic [caf_pkg::CSR_W-1:0]          pwdata,
   output logic [caf_pkg::CSR_W-1:0]               prdata,
   output logic                                    pready
);

   import caf_pkg::*;

   localparam int NUM_STAGES = 13;
   localparam int AXES_DEPTH = 9;   // axes are needed again at the rotation stage
   localparam int A_DEPTH    = 5;   // direction cosines are needed at the derivative

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [CSR_W-1:0] k1_ff, k1_in;
   logic [CSR_W-1:0] k2_ff, k2_in;
   csr_index_type    csr_index;
   logic             csr_write;

   assign csr_index = csr_index_type'(paddr[2]);
   assign csr_write = psel & penable & pwrite & pready;
   assign pready    = 1'b1;

   always_comb begin
      k1_in = k1_ff;
      k2_in = k2_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_K_FIRST:  k1_in = pwdata;
            CSR_K_SECOND: k2_in = pwdata;
            default:      k1_in = k1_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         CSR_K_FIRST:  prdata = k1_ff;
         CSR_K_SECOND: prdata = k2_ff;
         default:      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k1_ff <= '0;
         k2_ff <= '0;
      end else begin
         k1_ff <= k1_in;
         k2_ff <= k2_in;
      end
   end

   // ------------------------------------------------------------------
   // Valid chain and side pipelines
   // ------------------------------------------------------------------
   logic [NUM_STAGES-1:0] valid_ff, valid_in;

   assign busy     = 1'b0;
   assign valid_in = {valid_ff[NUM_STAGES-2:0], start};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   logic signed [VEC_W-1:0] mag [3];
   axes_type                axes_in;
   axes_type                axes_ff [AXES_DEPTH];

   assign mag[0] = req_mag_x;
   assign mag[1] = req_mag_y;
   assign mag[2] = req_mag_z;

   always_comb begin
      axes_in[0] = req_axis1_x;
      axes_in[1] = req_axis1_y;
      axes_in[2] = req_axis1_z;
      axes_in[3] = req_axis2_x;
      axes_in[4] = req_axis2_y;
      axes_in[5] = req_axis2_z;
      axes_in[6] = req_axis3_x;
      axes_in[7] = req_axis3_y;
      axes_in[8] = req_axis3_z;
   end

   always_ff @(posedge clock) begin
      axes_ff[0] <= axes_in;
      for (int i = 1; i < AXES_DEPTH; i++) begin
         axes_ff[i] <= axes_ff[i-1];
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: component products u_jc * m_c
   // ------------------------------------------------------------------
   logic signed [31:0] mu_ff [9];

   for (genvar n = 0; n < 9; n++) begin : g_mu
      logic signed [31:0] mu_in;
      assign mu_in = $signed(axes_in[n]) * mag[n % 3];
      always_ff @(posedge clock) begin
         mu_ff[n] <= mu_in;
      end
   end

   // ------------------------------------------------------------------
   // Stages 2 to 9: per-axis chain from projection to derivative
   // ------------------------------------------------------------------
   logic signed [17:0] a_pipe_ff [3][A_DEPTH];
   logic        [18:0] s_ff     [3];
   logic        [21:0] p_ff     [3];
   logic        [19:0] ssum_ff  [3];
   logic signed [52:0] t1_ff    [3];
   logic signed [54:0] t2_ff    [3];
   logic signed [54:0] t_ff     [3];
   logic signed [44:0] whi_ff   [3];
   logic signed [46:0] wlo_ff   [3];
   logic signed [73:0] prod_ff  [3];
   logic signed [FIELD_W-1:0] d_ff [3];

   logic signed [CSR_W-1:0] k1_s;
   logic signed [CSR_W-1:0] k2_s;
   assign k1_s = $signed(k1_ff);
   assign k2_s = $signed(k2_ff);

   for (genvar j = 0; j < 3; j++) begin : g_axis
      localparam int K = (j + 1) % 3;
      localparam int L = (j + 2) % 3;

      logic signed [33:0] acc;
      logic        [33:0] acc_rnd;
      logic signed [17:0] a_in;
      logic signed [35:0] sq;
      logic        [35:0] sq_rnd;
      logic        [18:0] s_in;
      logic        [37:0] pp;
      logic        [37:0] pp_rnd;
      logic        [21:0] p_in;
      logic        [19:0] ssum_in;
      logic signed [52:0] t1_in;
      logic signed [54:0] t2_in;
      logic signed [54:0] t_in;
      logic signed [44:0] whi_in;
      logic signed [46:0] wlo_in;
      logic signed [73:0] prod_in;
      logic               prod_pos;
      logic signed [73:0] neg_rnd;
      logic signed [73:0] neg_q;
      logic        [26:0] neg_top;
      logic signed [FIELD_W-1:0] d_in;

      // Direction cosine, rounded half away from zero.
      assign acc     = 34'(mu_ff[3*j]) + 34'(mu_ff[3*j+1]) + 34'(mu_ff[3*j+2]);
      assign acc_rnd = acc + 34'd16384 - {33'd0, acc[33]};
      assign a_in    = acc_rnd[32:15];

      // Squared cosine, never negative.
      assign sq     = a_pipe_ff[j][0] * a_pipe_ff[j][0];
      assign sq_rnd = sq + 36'd16384;
      assign s_in   = sq_rnd[33:15];

      // Product of the other two squares, and their sum.
      assign pp      = 38'(s_ff[K]) * 38'(s_ff[L]);
      assign pp_rnd  = pp + 38'd16384;
      assign p_in    = pp_rnd[36:15];
      assign ssum_in = 20'(s_ff[K]) + 20'(s_ff[L]);

      // Weighting by the anisotropy constants.
      assign t1_in = k1_s * $signed({1'b0, ssum_ff[j]});
      assign t2_in = k2_s * $signed({1'b0, p_ff[j]});
      assign t_in  = 55'(t1_ff[j]) + t2_ff[j];

      // Cosine times weight, split on the wide operand.
      assign whi_in  = a_pipe_ff[j][A_DEPTH-1] * $signed(t_ff[j][54:28]);
      assign wlo_in  = a_pipe_ff[j][A_DEPTH-1] * $signed({1'b0, t_ff[j][27:0]});
      assign prod_in = (74'(whi_ff[j]) <<< 28) + 74'(wlo_ff[j]);

      // Negate and round by 2^14 in one add: ~x + 1 + half - (result < 0).
      assign prod_pos = ~prod_ff[j][73] & (prod_ff[j] != '0);
      assign neg_rnd  = ~prod_ff[j] + (prod_pos ? 74'd8192 : 74'd8193);
      assign neg_q    = neg_rnd >>> 14;
      assign neg_top  = neg_q[73:47];

      always_comb begin
         if (neg_top == '0 || neg_top == '1) begin
            d_in = neg_q[FIELD_W-1:0];
         end else if (neg_q[73]) begin
            d_in = FIELD_MIN;
         end else begin
            d_in = FIELD_MAX;
         end
      end

      always_ff @(posedge clock) begin
         a_pipe_ff[j][0] <= a_in;
         for (int i = 1; i < A_DEPTH; i++) begin
            a_pipe_ff[j][i] <= a_pipe_ff[j][i-1];
         end
         s_ff[j]    <= s_in;
         p_ff[j]    <= p_in;
         ssum_ff[j] <= ssum_in;
         t1_ff[j]   <= t1_in;
         t2_ff[j]   <= t2_in;
         t_ff[j]    <= t_in;
         whi_ff[j]  <= whi_in;
         wlo_ff[j]  <= wlo_in;
         prod_ff[j] <= prod_in;
         d_ff[j]    <= d_in;
      end
   end

   // ------------------------------------------------------------------
   // Stages 10 to 13: rotation back through the axis matrix
   // ------------------------------------------------------------------
   logic signed [39:0] fhi_ff [9];
   logic signed [40:0] flo_ff [9];
   logic signed [63:0] fp_ff  [9];
   logic signed [65:0] fsum_ff [3];
   logic signed [FIELD_W-1:0] field_ff [3];

   // Element c*3+j holds the contribution of axis j to component c.
   for (genvar n = 0; n < 9; n++) begin : g_rot
      localparam int C = n / 3;
      localparam int J = n % 3;

      logic signed [VEC_W-1:0] u_elem;
      logic signed [39:0]      fhi_in;
      logic signed [40:0]      flo_in;
      logic signed [63:0]      fp_in;

      assign u_elem = $signed(axes_ff[AXES_DEPTH-1][J*3+C]);
      assign fhi_in = u_elem * $signed(d_ff[J][47:24]);
      assign flo_in = u_elem * $signed({1'b0, d_ff[J][23:0]});
      assign fp_in  = (64'(fhi_ff[n]) <<< 24) + 64'(flo_ff[n]);

      always_ff @(posedge clock) begin
         fhi_ff[n] <= fhi_in;
         flo_ff[n] <= flo_in;
         fp_ff[n]  <= fp_in;
      end
   end

   for (genvar c = 0; c < 3; c++) begin : g_field
      logic signed [65:0] fsum_in;
      logic signed [65:0] f_rnd;
      logic signed [65:0] f_q;
      logic        [18:0] f_top;
      logic signed [FIELD_W-1:0] field_in;

      assign fsum_in = 66'(fp_ff[3*c]) + 66'(fp_ff[3*c+1]) + 66'(fp_ff[3*c+2]);
      assign f_rnd   = fsum_ff[c] + 66'd16384 - {65'd0, fsum_ff[c][65]};
      assign f_q     = f_rnd >>> 15;
      assign f_top   = f_q[65:47];

      always_comb begin
         if (f_top == '0 || f_top == '1) begin
            field_in = f_q[FIELD_W-1:0];
         end else if (f_q[65]) begin
            field_in = FIELD_MIN;
         end else begin
            field_in = FIELD_MAX;
         end
      end

      always_ff @(posedge clock) begin
         fsum_ff[c]  <= fsum_in;
         field_ff[c] <= field_in;
      end
   end

   assign rsp_valid   = valid_ff[NUM_STAGES-1];
   assign rsp_field_x = field_ff[0];
   assign rsp_field_y = field_ff[1];
   assign rsp_field_z = field_ff[2];

endmodule

`default_nettype wire

@@ tb/sv/caf_checker.sv @@
// Checker for the cubic anisotropy field block: predicts each node's field and compares.
module caf_checker (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   input  wire logic                                  busy,
   input  wire logic [11:0][caf_pkg::VEC_W-1:0]       req_node,
   input  wire logic                                  rsp_valid,
   input  wire logic signed [caf_pkg::FIELD_W-1:0]    rsp_field_x,
   input  wire logic signed [caf_pkg::FIELD_W-1:0]    rsp_field_y,
   input  wire logic signed [caf_pkg::FIELD_W-1:0]    rsp_field_z,
   input  wire logic                                  psel,
   input  wire logic                                  penable,
   input  wire logic                                  pwrite,
   input  wire logic                                  pready,
   input  wire logic [2:0]                            paddr,
   input  wire logic [caf_pkg::CSR_W-1:0]             pwdata,
   output int                                         outstanding,
   output int                                         errors
);
   timeunit 1ns;
   timeprecision 1ps;

   import caf_pkg::*;

   typedef struct packed {
      logic signed [FIELD_W-1:0] x;
      logic signed [FIELD_W-1:0] y;
      logic signed [FIELD_W-1:0] z;
   } field_vec_type;

   field_vec_type     field_q [$];
   logic signed [31:0] k_first;
   logic signed [31:0] k_second;
   int                fail_count = 0;
   int                field_count = 0;

   // Divide by 2^sh, round half away from zero, saturate to the field range.
   function automatic logic signed [FIELD_W-1:0] round_sat(input logic signed [127:0] v,
                                                          input int sh);
      logic signed [127:0] mag;
      logic signed [127:0] lim;
      logic                neg;
      neg = v[127];
      mag = neg ? -v : v;
      mag = (mag + (128'sd1 <<< (sh - 1))) >>> sh;
      if (neg) begin
         lim = FIELD_MIN;
         lim = -lim;
      end else begin
         lim = FIELD_MAX;
      end
      if (mag > lim)
         mag = lim;
      if (neg)
         mag = -mag;
      return mag[FIELD_W-1:0];
   endfunction

   function automatic field_vec_type predict_field(input logic [11:0][VEC_W-1:0] nd,
                                                  input logic signed [31:0] kf,
                                                  input logic signed [31:0] ks);
      logic signed [127:0] mv [3];
      logic signed [127:0] uv [3][3];
      logic signed [127:0] cosv [3];
      logic signed [127:0] sq [3];
      logic signed [127:0] drv [3];
      logic signed [127:0] hv [3];
      logic signed [127:0] acc;
      logic signed [127:0] sq_prod;
      logic signed [127:0] tsum;
      logic signed [127:0] k1w;
      logic signed [127:0] k2w;
      int                  j;
      int                  c;
      int                  k;
      int                  l;
      field_vec_type       r;
      k1w = kf;
      k2w = ks;
      for (c = 0; c < 3; c++)
         mv[c] = $signed(nd[c]);
      for (j = 0; j < 3; j++)
         for (c = 0; c < 3; c++)
            uv[j][c] = $signed(nd[3 + 3 * j + c]);
      // Direction cosines and their squares.
      for (j = 0; j < 3; j++) begin
         acc = uv[j][0] * mv[0] + uv[j][1] * mv[1] + uv[j][2] * mv[2];
         cosv[j] = round_sat(acc, 15);
         sq[j] = round_sat(cosv[j] * cosv[j], 15);
      end
      // Derivative along each axis, with the other two taken in cyclic order.
      for (j = 0; j < 3; j++) begin
         k = (j + 1) % 3;
         l = (j + 2) % 3;
         sq_prod = round_sat(sq[k] * sq[l], 15);
         tsum = k1w * (sq[k] + sq[l]) + k2w * sq_prod;
         drv[j] = round_sat(-(cosv[j] * tsum), 14);
      end
      // Rotate back into the lab frame.
      for (c = 0; c < 3; c++) begin
         acc = uv[0][c] * drv[0] + uv[1][c] * drv[1] + uv[2][c] * drv[2];
         hv[c] = round_sat(acc, 15);
      end
      r.x = hv[0][FIELD_W-1:0];
      r.y = hv[1][FIELD_W-1:0];
      r.z = hv[2][FIELD_W-1:0];
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      if (fail_count < 40)
         $display("caf_checker: %s", msg);
      fail_count++;
   endtask

   always @(posedge clock) begin
      field_vec_type want;
      if (reset) begin
         k_first = '0;
         k_second = '0;
         field_q.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (csr_index_type'(paddr[2]))
               CSR_K_FIRST:  k_first = pwdata;
               CSR_K_SECOND: k_second = pwdata;
               default: ;
            endcase
         end
         if (start && !busy)
            field_q.push_back(predict_field(req_node, k_first, k_second));
         if (rsp_valid) begin
            if (field_q.size() == 0) begin
               report_mismatch($sformatf("field %0d arrived with no node pending",
                                         field_count));
            end else begin
               want = field_q.pop_front();
               if (rsp_field_x !== want.x)
                  report_mismatch($sformatf("field %0d x: got %0d, predicted %0d",
                                            field_count, rsp_field_x, want.x));
               if (rsp_field_y !== want.y)
                  report_mismatch($sformatf("field %0d y: got %0d, predicted %0d",
                                            field_count, rsp_field_y, want.y));
               if (rsp_field_z !== want.z)
                  report_mismatch($sformatf("field %0d z: got %0d, predicted %0d",
                                            field_count, rsp_field_z, want.z));
            end
            field_count++;
         end
      end
      outstanding <= field_q.size();
      errors <= fail_count;
   end

endmodule

@@ tb/sv/tb.sv @@
// Testbench top for the cubic anisotropy field block: stimulus, register setup and verdict.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import caf_pkg::*;

   typedef logic [11:0][VEC_W-1:0] node_vec_type;

   localparam logic [VEC_W-1:0] ONE  = 16'sh7FFF;
   localparam logic [VEC_W-1:0] NEG  = 16'sh8000;
   localparam logic [VEC_W-1:0] HALF = 16'sd23170;   // 1/sqrt(2)
   localparam logic [VEC_W-1:0] DIAG = 16'sd18918;   // 1/sqrt(3)

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        start = 1'b0;
   node_vec_type                req_node = '0;
   logic                        psel = 1'b0;
   logic                        penable = 1'b0;
   logic                        pwrite = 1'b0;
   logic [2:0]                  paddr = '0;
   logic [CSR_W-1:0]            pwdata = '0;
   logic                        busy;
   logic                        rsp_valid;
   logic signed [FIELD_W-1:0]   rsp_field_x;
   logic signed [FIELD_W-1:0]   rsp_field_y;
   logic signed [FIELD_W-1:0]   rsp_field_z;
   logic [CSR_W-1:0]            prdata;
   logic                        pready;
   int                          outstanding;
   int                          failures;

   always #2 clock = ~clock;

   cubic_anisotropy_field dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_mag_x   (req_node[0]),
      .req_mag_y   (req_node[1]),
      .req_mag_z   (req_node[2]),
      .req_axis1_x (req_node[3]),
      .req_axis1_y (req_node[4]),
      .req_axis1_z (req_node[5]),
      .req_axis2_x (req_node[6]),
      .req_axis2_y (req_node[7]),
      .req_axis2_z (req_node[8]),
      .req_axis3_x (req_node[9]),
      .req_axis3_y (req_node[10]),
      .req_axis3_z (req_node[11]),
      .rsp_valid   (rsp_valid),
      .rsp_field_x (rsp_field_x),
      .rsp_field_y (rsp_field_y),
      .rsp_field_z (rsp_field_z),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   caf_checker scoreboard (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_node    (req_node),
      .rsp_valid   (rsp_valid),
      .rsp_field_x (rsp_field_x),
      .rsp_field_y (rsp_field_y),
      .rsp_field_z (rsp_field_z),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .pready      (pready),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .outstanding (outstanding),
      .errors      (failures)
   );

   function automatic node_vec_type pack_node(
      input logic [VEC_W-1:0] mx, my, mz,
      input logic [VEC_W-1:0] a1x, a1y, a1z,
      input logic [VEC_W-1:0] a2x, a2y, a2z,
      input logic [VEC_W-1:0] a3x, a3y, a3z);
      return {a3z, a3y, a3x, a2z, a2y, a2x, a1z, a1y, a1x, mz, my, mx};
   endfunction

   function automatic logic [VEC_W-1:0] to_q15(input real r);
      return 16'($rtoi(r * 32767.0));
   endfunction

   function automatic node_vec_type corner_node(input int n);
      case (n)
         0: return pack_node(ONE, '0, '0, ONE, '0, '0, '0, ONE, '0, '0, '0, ONE);
         1: return pack_node(HALF, HALF, '0, ONE, '0, '0, '0, ONE, '0, '0, '0, ONE);
         2: return pack_node(DIAG, DIAG, DIAG, ONE, '0, '0, '0, ONE, '0, '0, '0, ONE);
         3: return {12{NEG}};
         4: return {12{ONE}};
         5: return pack_node('0, NEG, '0, '0, '0, ONE, NEG, '0, '0, '0, ONE, '0);
         6: return pack_node(ONE, '0, '0, HALF, HALF, '0, -HALF, HALF, '0, '0, '0, ONE);
         7: return pack_node(ONE, NEG, ONE, NEG, ONE, NEG, ONE, NEG, ONE, NEG, NEG, ONE);
         default: return '0;
      endcase
   endfunction

   // Mostly unit magnetization on orthonormal frames, some raw bit patterns.
   function automatic node_vec_type random_node();
      node_vec_type nd;
      real     vx, vy, vz, len, g, b, cg, sg, cb, sb;
      int      perm [3];
      int      j, s, t;
      int      kind;
      kind = $urandom_range(0, 9);
      if (kind < 3) begin
         for (j = 0; j < 12; j++)
            nd[j] = 16'($urandom());
         return nd;
      end
      do begin
         vx = real'($urandom_range(0, 65535)) - 32768.0;
         vy = real'($urandom_range(0, 65535)) - 32768.0;
         vz = real'($urandom_range(0, 65535)) - 32768.0;
         len = $sqrt(vx * vx + vy * vy + vz * vz);
      end while (len < 1.0);
      nd = '0;
      nd[0] = to_q15(vx / len);
      nd[1] = to_q15(vy / len);
      nd[2] = to_q15(vz / len);
      if (kind < 6) begin
         // Signed permutation of the crystal axes.
         perm = '{0, 1, 2};
         for (j = 0; j < 2; j++) begin
            s = $urandom_range(j, 2);
            t = perm[j];
            perm[j] = perm[s];
            perm[s] = t;
         end
         for (j = 0; j < 3; j++)
            nd[3 + 3 * j + perm[j]] = $urandom_range(0, 1) ? ONE : NEG;
      end else begin
         g = real'($urandom_range(0, 9999)) / 10000.0 * 6.283185307;
         b = real'($urandom_range(0, 9999)) / 10000.0 * 6.283185307;
         cg = $cos(g);
         sg = $sin(g);
         cb = $cos(b);
         sb = $sin(b);
         nd[3]  = to_q15(cg);
         nd[4]  = to_q15(sg);
         nd[5]  = '0;
         nd[6]  = to_q15(-sg * cb);
         nd[7]  = to_q15(cg * cb);
         nd[8]  = to_q15(sb);
         nd[9]  = to_q15(sg * sb);
         nd[10] = to_q15(-cg * sb);
         nd[11] = to_q15(cb);
      end
      return nd;
   endfunction

   // Holds start until the item is taken, then leaves start low in each
   // following cycle with the given chance.
   task automatic send_node(input node_vec_type nd, input int idle_pct);
      req_node <= nd;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic wait_fields_drained();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_k(input csr_index_type idx, input logic [CSR_W-1:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   initial begin
      #1000000;
      $display("tb: done, errors");
      $finish;
   end

   initial begin
      int               p;
      int               i;
      int               idle_pct;
      logic [CSR_W-1:0] kf;
      logic [CSR_W-1:0] ks;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Both constants still at their reset value of zero.
      send_node(corner_node(0), 0);
      send_node(corner_node(3), 0);
      send_node(corner_node(4), 0);
      wait_fields_drained();

      write_k(CSR_K_FIRST, 32'h7FFF_FFFF);
      write_k(CSR_K_SECOND, 32'h8000_0000);
      for (i = 0; i < 9; i++)
         send_node(corner_node(i), 0);
      wait_fields_drained();

      write_k(CSR_K_FIRST, 32'h8000_0000);
      write_k(CSR_K_SECOND, 32'h7FFF_FFFF);
      for (i = 0; i < 9; i++)
         send_node(corner_node(i), 0);
      wait_fields_drained();

      for (p = 0; p < 8; p++) begin
         case (p)
            0: begin kf = 32'h7FFF_FFFF; ks = 32'h7FFF_FFFF; end
            1: begin kf = 32'h8000_0000; ks = 32'h8000_0000; end
            2: begin kf = 32'd48000; ks = -32'sd15000; end
            4: begin kf = '0; ks = 32'h7FFF_FFFF; end
            5: begin kf = 32'h8000_0000; ks = '0; end
            6: begin
               kf = $urandom_range(0, 200000) - 100000;
               ks = $urandom_range(0, 200000) - 100000;
            end
            default: begin kf = $urandom(); ks = $urandom(); end
         endcase
         write_k(CSR_K_FIRST, kf);
         write_k(CSR_K_SECOND, ks);
         idle_pct = (p % 3 == 1) ? 54 : ((p % 3 == 2) ? 37 : 0);
         for (i = 0; i < 60; i++) begin
            // Let the pipeline empty completely once in the middle of a phase.
            if (p == 4 && i == 30)
               wait_fields_drained();
            send_node(random_node(), idle_pct);
         end
         wait_fields_drained();
      end

      repeat (20) @(posedge clock);
      if (failures == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule
